// ===== src/cmp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package cmp_pkg;

    localparam int SAMPLE_WIDTH = 16;
    localparam int MAG_W        = SAMPLE_WIDTH;
    localparam int PHASE_W      = 15;
    localparam int SUM_W        = 2 * SAMPLE_WIDTH + 1;
    localparam int SQRT_STEPS   = SAMPLE_WIDTH;
    localparam int CORDIC_STEPS = 24;
    localparam int CORDIC_W     = 49;
    localparam int SCALE_SH     = 46 - SAMPLE_WIDTH;
    localparam int ANGLE_W      = 27;
    localparam int ROUND_SH     = 11;
    localparam int PIPE_STEPS   = (CORDIC_STEPS > SQRT_STEPS) ? CORDIC_STEPS : SQRT_STEPS;
    localparam int HALF_PI_Q13  = 12868;

    typedef logic signed [ANGLE_W-1:0]  t_angle;
    typedef logic signed [PHASE_W-1:0]  t_phase;
    typedef logic signed [CORDIC_W-1:0] t_cw;

    localparam t_phase PHASE_MAX = t_phase'(HALF_PI_Q13);
    localparam t_phase PHASE_MIN = t_phase'(-HALF_PI_Q13);

    localparam t_angle ATAN_TAB [CORDIC_STEPS] = '{
        t_angle'(13176795), t_angle'(7778716), t_angle'(4110060), t_angle'(2086331),
        t_angle'(1047214),  t_angle'(524117),  t_angle'(262123),  t_angle'(131069),
        t_angle'(65536),    t_angle'(32768),   t_angle'(16384),   t_angle'(8192),
        t_angle'(4096),     t_angle'(2048),    t_angle'(1024),    t_angle'(512),
        t_angle'(256),      t_angle'(128),     t_angle'(64),      t_angle'(32),
        t_angle'(16),       t_angle'(8),       t_angle'(4),       t_angle'(2)
    };

    typedef struct packed {
        t_cw    x;
        t_cw    y;
        t_angle z;
    } t_cordic;

    typedef struct packed {
        logic [SUM_W-1:0] rem;
        logic [MAG_W-1:0] root;
    } t_sqrt;

    typedef struct packed {
        logic re_zero;
        logic im_zero;
        logic im_neg;
        logic flip;
    } t_flags;

endpackage

`default_nettype wire

// ===== src/complex_to_magnitude_phase.sv =====
// Complex sample to magnitude and folded phase.
// Input channel: i_valid / o_ready with i_real_part and i_imag_part, signed.
// Output channel: o_valid / i_ready with o_magnitude (rounded sqrt of the
// power, unsigned), o_phase (atan(im/re) in Q2.13 radians, within +-pi/2)
// and o_invalid (both parts zero, phase forced to 0).
// One word is taken per cycle unless the output stalls. After it is
// accepted, a word passes through one input stage, one squaring stage,
// one setup stage, 24 CORDIC vectoring stages (the magnitude square root
// runs one bit per stage alongside them) and the output register.
// Throughput is one word per clock while the output is not stalled.
// When the receiver stalls (o_valid high, i_ready low) the whole pipeline
// holds, o_ready drops and the presented word stays unchanged; nothing is
// lost or repeated.
// Reset (i_rst_n low at a clock edge) clears all valid bits; o_ready is
// high again in the first cycle after reset.
`timescale 1ns / 1ps
`default_nettype none

module complex_to_magnitude_phase (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output logic                                     o_ready,
    input  wire logic signed [cmp_pkg::SAMPLE_WIDTH-1:0] i_real_part,
    input  wire logic signed [cmp_pkg::SAMPLE_WIDTH-1:0] i_imag_part,
    output logic                                     o_valid,
    input  wire logic                                i_ready,
    output logic [cmp_pkg::MAG_W-1:0]                o_magnitude,
    output logic signed [cmp_pkg::PHASE_W-1:0]       o_phase,
    output logic                                     o_invalid
);
    import cmp_pkg::*;

    localparam int LAST = PIPE_STEPS - 1;

    logic en;

    logic                           r_a_vld;
    logic signed [SAMPLE_WIDTH-1:0] r_a_re;
    logic signed [SAMPLE_WIDTH-1:0] r_a_im;

    logic [SAMPLE_WIDTH-1:0]   n_b_ar;
    logic [SAMPLE_WIDTH-1:0]   n_b_ai;
    t_flags                    n_b_flags;
    logic                      r_b_vld;
    logic [SAMPLE_WIDTH-1:0]   r_b_ar;
    logic [SAMPLE_WIDTH-1:0]   r_b_ai;
    logic [2*SAMPLE_WIDTH-1:0] r_b_sqr;
    logic [2*SAMPLE_WIDTH-1:0] r_b_sqi;
    t_flags                    r_b_flags;

    t_cordic n_c_cord;
    t_sqrt   n_c_sqrt;
    logic    r_c_vld;
    t_cordic r_c_cord;
    t_sqrt   r_c_sqrt;
    t_flags  r_c_flags;

    logic    r_p_vld   [PIPE_STEPS];
    t_cordic r_p_cord  [PIPE_STEPS];
    t_sqrt   r_p_sqrt  [PIPE_STEPS];
    t_flags  r_p_flags [PIPE_STEPS];

    t_angle             z_clip;
    t_angle             z_round;
    t_phase             ph_abs;
    t_phase             n_phase;
    logic               n_invalid;
    logic [MAG_W-1:0]   n_mag;
    logic               r_out_vld;
    logic [MAG_W-1:0]   r_out_mag;
    t_phase             r_out_phase;
    logic               r_out_inv;

    assign en      = !r_out_vld || i_ready;
    assign o_ready = en;

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (en) begin
            r_a_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_re <= i_real_part;
            r_a_im <= i_imag_part;
        end
    end

    // magnitudes and squares
    always_comb begin
        n_b_ar            = r_a_re[SAMPLE_WIDTH-1] ? SAMPLE_WIDTH'(-r_a_re) : SAMPLE_WIDTH'(r_a_re);
        n_b_ai            = r_a_im[SAMPLE_WIDTH-1] ? SAMPLE_WIDTH'(-r_a_im) : SAMPLE_WIDTH'(r_a_im);
        n_b_flags.re_zero = (r_a_re == '0);
        n_b_flags.im_zero = (r_a_im == '0);
        n_b_flags.im_neg  = r_a_im[SAMPLE_WIDTH-1];
        n_b_flags.flip    = r_a_re[SAMPLE_WIDTH-1] ^ r_a_im[SAMPLE_WIDTH-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (en) begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_b_ar    <= n_b_ar;
            r_b_ai    <= n_b_ai;
            r_b_sqr   <= n_b_ar * n_b_ar;
            r_b_sqi   <= n_b_ai * n_b_ai;
            r_b_flags <= n_b_flags;
        end
    end

    // power sum and CORDIC setup
    always_comb begin
        n_c_sqrt.rem  = SUM_W'(r_b_sqr) + SUM_W'(r_b_sqi);
        n_c_sqrt.root = '0;
        n_c_cord.x    = $signed(CORDIC_W'(r_b_ar) << SCALE_SH);
        n_c_cord.y    = $signed(CORDIC_W'(r_b_ai) << SCALE_SH);
        n_c_cord.z    = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (en) begin
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_c_cord  <= n_c_cord;
            r_c_sqrt  <= n_c_sqrt;
            r_c_flags <= r_b_flags;
        end
    end

    // vectoring and square root stages
    for (genvar k = 0; k < PIPE_STEPS; k++) begin : g_step
        logic    vin;
        t_cordic cin;
        t_sqrt   sin;
        t_flags  fin;
        t_cordic n_cord;
        t_sqrt   n_sqrt;

        if (k == 0) begin : g_first
            assign vin = r_c_vld;
            assign cin = r_c_cord;
            assign sin = r_c_sqrt;
            assign fin = r_c_flags;
        end else begin : g_next
            assign vin = r_p_vld[k-1];
            assign cin = r_p_cord[k-1];
            assign sin = r_p_sqrt[k-1];
            assign fin = r_p_flags[k-1];
        end

        if (k < CORDIC_STEPS) begin : g_cordic
            t_cw dx;
            t_cw dy;
            always_comb begin
                dx     = $signed(cin.y) >>> k;
                dy     = $signed(cin.x) >>> k;
                n_cord = cin;
                if (!cin.y[CORDIC_W-1]) begin
                    n_cord.x = $signed(cin.x) + dx;
                    n_cord.y = $signed(cin.y) - dy;
                    n_cord.z = $signed(cin.z) + ATAN_TAB[k];
                end else begin
                    n_cord.x = $signed(cin.x) - dx;
                    n_cord.y = $signed(cin.y) + dy;
                    n_cord.z = $signed(cin.z) - ATAN_TAB[k];
                end
            end
        end else begin : g_cordic_hold
            assign n_cord = cin;
        end

        if (k < SQRT_STEPS) begin : g_sqrt
            localparam int B = SQRT_STEPS - 1 - k;
            logic [SUM_W-1:0] trial;
            assign trial = (SUM_W'(sin.root) << (B + 1)) | (SUM_W'(1) << (2 * B));
            always_comb begin
                n_sqrt = sin;
                if (sin.rem >= trial) begin
                    n_sqrt.rem  = sin.rem - trial;
                    n_sqrt.root = sin.root | (MAG_W'(1) << B);
                end
            end
        end else begin : g_sqrt_hold
            assign n_sqrt = sin;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_p_vld[k] <= 1'b0;
            end else if (en) begin
                r_p_vld[k] <= vin;
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_p_cord[k]  <= n_cord;
                r_p_sqrt[k]  <= n_sqrt;
                r_p_flags[k] <= fin;
            end
        end
    end

    // round, clamp, fold sign, special cases
    always_comb begin
        z_clip  = r_p_cord[LAST].z[ANGLE_W-1] ? '0 : r_p_cord[LAST].z;
        z_round = (z_clip + t_angle'(1 << (ROUND_SH - 1))) >>> ROUND_SH;
        ph_abs  = (z_round > t_angle'(HALF_PI_Q13)) ? PHASE_MAX : t_phase'(z_round);
        n_mag   = r_p_sqrt[LAST].root
                + MAG_W'(r_p_sqrt[LAST].rem > SUM_W'(r_p_sqrt[LAST].root));
        n_invalid = 1'b0;
        priority if (r_p_flags[LAST].re_zero && r_p_flags[LAST].im_zero) begin
            n_phase   = '0;
            n_invalid = 1'b1;
        end else if (r_p_flags[LAST].re_zero) begin
            n_phase = r_p_flags[LAST].im_neg ? PHASE_MIN : PHASE_MAX;
        end else if (r_p_flags[LAST].im_zero) begin
            n_phase = '0;
        end else begin
            n_phase = r_p_flags[LAST].flip ? t_phase'(-ph_abs) : ph_abs;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_out_vld <= r_p_vld[LAST];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_mag   <= n_mag;
            r_out_phase <= n_phase;
            r_out_inv   <= n_invalid;
        end
    end

    assign o_valid     = r_out_vld;
    assign o_magnitude = r_out_mag;
    assign o_phase     = r_out_phase;
    assign o_invalid   = r_out_inv;

endmodule

`default_nettype wire

// ===== src/cmp_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module cmp_checker (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              o_ready,
    input wire logic                              o_valid,
    input wire logic                              i_ready,
    input wire logic [cmp_pkg::MAG_W-1:0]         o_magnitude,
    input wire logic signed [cmp_pkg::PHASE_W-1:0] o_phase,
    input wire logic                              o_invalid
);
    import cmp_pkg::*;

    // hold a stalled output word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_magnitude) && $stable(o_phase)
                               && $stable(o_invalid))
        else $error("output word changed while stalled");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_invalid |-> o_magnitude == '0 && o_phase == '0)
        else $error("invalid word with nonzero magnitude or phase");

    a_valid_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_invalid |-> o_magnitude != '0)
        else $error("nonzero sample gave zero magnitude");

    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_phase <= PHASE_MAX && o_phase >= PHASE_MIN)
        else $error("phase outside half-pi range");

    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_valid |-> o_ready)
        else $error("input stalled with empty output");

endmodule

bind complex_to_magnitude_phase cmp_checker u_cmp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_ready     (o_ready),
    .o_valid     (o_valid),
    .i_ready     (i_ready),
    .o_magnitude (o_magnitude),
    .o_phase     (o_phase),
    .o_invalid   (o_invalid)
);

`default_nettype wire
